// ===== sv/cdof_pkg.sv =====
// ============================================================================
// cdof_pkg
// Shared widths, codes, microcode format and control store of the CSR
// degree-one folding unit.
// ============================================================================
package cdof_pkg;

    localparam int IDX_W  = 12;
    localparam int VAL_W  = 13;
    localparam int OFF_W  = 13;
    localparam int EDGE_W = 10;
    localparam int DEG_W  = 10;
    localparam int CNT_W  = 11;
    localparam int KIND_W = 2;
    localparam int POS_W  = 10;
    localparam int WALK_W = OFF_W + 1;
    localparam int UPC_W  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [UPC_W-1:0] t_upc;

    // Control store addresses
    localparam t_upc UPC_IDLE      = 4'd0;
    localparam t_upc UPC_DISPATCH  = 4'd1;
    localparam t_upc UPC_HOST_EMIT = 4'd2;
    localparam t_upc UPC_RD_DOFF   = 4'd3;
    localparam t_upc UPC_RD_HUB    = 4'd4;
    localparam t_upc UPC_GET_HUB   = 4'd5;
    localparam t_upc UPC_GET_ROW   = 4'd6;
    localparam t_upc UPC_GET_EBASE = 4'd7;
    localparam t_upc UPC_WALK_RD   = 4'd8;
    localparam t_upc UPC_WALK_CMP  = 4'd9;
    localparam t_upc UPC_SWAP_BASE = 4'd10;
    localparam t_upc UPC_BUMP_D_RD = 4'd11;
    localparam t_upc UPC_BUMP_D_WR = 4'd12;
    localparam t_upc UPC_BUMP_H_RD = 4'd13;
    localparam t_upc UPC_BUMP_H_WR = 4'd14;
    localparam t_upc UPC_FOLD_EMIT = 4'd15;

    typedef enum logic [2:0] {
        REQ_WR_OFF  = 3'd0,
        REQ_WR_EDGE = 3'd1,
        REQ_WR_DEG  = 3'd2,
        REQ_FOLD    = 3'd3,
        REQ_RD_OFF  = 3'd4,
        REQ_RD_EDGE = 3'd5,
        REQ_RD_DEG  = 3'd6
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        KIND_WR_ACK  = 2'd0,
        KIND_RD_DATA = 2'd1,
        KIND_FOLD    = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        U_NOP,
        U_HOST_ACC,
        U_HOST_EMIT,
        U_RD_DOFF,
        U_RD_HUB,
        U_GET_HUB,
        U_GET_ROW,
        U_GET_EBASE,
        U_WALK_RD,
        U_WALK_CMP,
        U_SWAP_BASE,
        U_BUMP_D_RD,
        U_BUMP_D_WR,
        U_BUMP_H_RD,
        U_BUMP_H_WR,
        U_FOLD_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_FOLD_OK,
        C_WALK_DONE,
        C_NO_MATCH
    } t_cond;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic fold_ok;
        logic walk_done;
        logic match;
    } t_stat;

    function automatic t_uword ucode_word(t_upc pc);
        t_uword w;
        case (pc)
            UPC_IDLE:      w = '{U_NOP,       C_NO_START,  UPC_IDLE};
            UPC_DISPATCH:  w = '{U_HOST_ACC,  C_FOLD_OK,   UPC_RD_DOFF};
            UPC_HOST_EMIT: w = '{U_HOST_EMIT, C_ALWAYS,    UPC_IDLE};
            UPC_RD_DOFF:   w = '{U_RD_DOFF,   C_NEXT,      UPC_IDLE};
            UPC_RD_HUB:    w = '{U_RD_HUB,    C_NEXT,      UPC_IDLE};
            UPC_GET_HUB:   w = '{U_GET_HUB,   C_NEXT,      UPC_IDLE};
            UPC_GET_ROW:   w = '{U_GET_ROW,   C_NEXT,      UPC_IDLE};
            UPC_GET_EBASE: w = '{U_GET_EBASE, C_NEXT,      UPC_IDLE};
            UPC_WALK_RD:   w = '{U_WALK_RD,   C_WALK_DONE, UPC_BUMP_D_RD};
            UPC_WALK_CMP:  w = '{U_WALK_CMP,  C_NO_MATCH,  UPC_WALK_RD};
            UPC_SWAP_BASE: w = '{U_SWAP_BASE, C_NEXT,      UPC_IDLE};
            UPC_BUMP_D_RD: w = '{U_BUMP_D_RD, C_NEXT,      UPC_IDLE};
            UPC_BUMP_D_WR: w = '{U_BUMP_D_WR, C_NEXT,      UPC_IDLE};
            UPC_BUMP_H_RD: w = '{U_BUMP_H_RD, C_NEXT,      UPC_IDLE};
            UPC_BUMP_H_WR: w = '{U_BUMP_H_WR, C_NEXT,      UPC_IDLE};
            UPC_FOLD_EMIT: w = '{U_FOLD_EMIT, C_ALWAYS,    UPC_IDLE};
            default:       w = '{U_NOP,       C_ALWAYS,    UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/cdof_ram.sv =====
// ============================================================================
// cdof_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module cdof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cdof_seq.sv =====
// ============================================================================
// cdof_seq
// Microcode sequencer: step counter, control store fetch and conditional
// jumps on datapath status.
// ============================================================================
module cdof_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cdof_pkg::t_stat  i_stat,
    output cdof_pkg::t_uword o_ctrl,
    output logic             o_busy
);

    import cdof_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w_word;
    logic   w_take;

    always_comb begin
        w_word = ucode_word(r_pc);
        case (w_word.cond)
            C_NEXT:      w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_START:  w_take = !i_start;
            C_FOLD_OK:   w_take = i_stat.fold_ok;
            C_WALK_DONE: w_take = i_stat.walk_done;
            C_NO_MATCH:  w_take = !i_stat.match;
            default:     w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.target : r_pc + t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_word;
    assign o_busy = (r_pc != UPC_IDLE);

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_pc == UPC_IDLE) |=> r_pc == UPC_DISPATCH)
        else $error("accepted beat did not enter dispatch");

    a_match_swaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == UPC_WALK_CMP && i_stat.match) |=> r_pc == UPC_SWAP_BASE)
        else $error("neighbor match did not lead to swap");

endmodule

// ===== sv/cdof_dp.sv =====
// ============================================================================
// cdof_dp
// Datapath: request capture, the three CSR stores, fold walk registers,
// fold counter and result registers, driven by one microcode word a cycle.
// ============================================================================
module cdof_dp #(
    parameter int NODE_COUNT = 1024,
    parameter int EDGE_SLOTS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [2:0]                    i_req_type,
    input  logic [cdof_pkg::IDX_W-1:0]    i_index,
    input  logic [cdof_pkg::VAL_W-1:0]    i_value,
    input  cdof_pkg::t_uword              i_ctrl,
    output cdof_pkg::t_stat               o_stat,
    output logic                          o_result_strobe,
    output logic [cdof_pkg::KIND_W-1:0]   o_result_kind,
    output logic [cdof_pkg::VAL_W-1:0]    o_read_value,
    output logic [cdof_pkg::EDGE_W-1:0]   o_hub_node,
    output logic                          o_match_found,
    output logic [cdof_pkg::POS_W-1:0]    o_match_position,
    output logic [cdof_pkg::CNT_W-1:0]    o_fold_count
);

    import cdof_pkg::*;

    localparam int OFF_DEPTH = NODE_COUNT + 1;
    localparam int OFF_AW    = $clog2(OFF_DEPTH);
    localparam int DEG_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int EDGE_AW   = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

    localparam logic [31:0] OFF_LIM  = 32'(OFF_DEPTH);
    localparam logic [31:0] NODE_LIM = 32'(NODE_COUNT);
    localparam logic [31:0] EDGE_LIM = 32'(EDGE_SLOTS);

    // Store ports
    logic               w_off_we,  w_deg_we,  w_edge_we;
    logic [OFF_AW-1:0]  w_off_waddr, w_off_raddr;
    logic [DEG_AW-1:0]  w_deg_waddr, w_deg_raddr;
    logic [EDGE_AW-1:0] w_edge_waddr, w_edge_raddr;
    logic [OFF_W-1:0]   w_off_wdata, w_off_rd;
    logic [DEG_W-1:0]   w_deg_wdata, w_deg_rd;
    logic [EDGE_W-1:0]  w_edge_wdata, w_edge_rd;

    // Request and walk registers
    logic [2:0]        r_type,    n_type;
    logic [IDX_W-1:0]  r_idx,     n_idx;
    logic [VAL_W-1:0]  r_val,     n_val;
    logic              r_hub_oob, n_hub_oob;
    logic [EDGE_W-1:0] r_hub,     n_hub;
    logic              r_hub_in,  n_hub_in;
    logic [OFF_W-1:0]  r_base,    n_base;
    logic [DEG_W-1:0]  r_deg,     n_deg;
    logic [DEG_W-1:0]  r_i,       n_i;
    logic              r_found,   n_found;
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [EDGE_W-1:0] r_ebase,   n_ebase;
    logic [CNT_W-1:0]  r_count,   n_count;

    // Result registers
    logic              r_strobe,    n_strobe;
    logic [KIND_W-1:0] r_out_kind,  n_out_kind;
    logic [VAL_W-1:0]  r_out_rval,  n_out_rval;
    logic [EDGE_W-1:0] r_out_hub,   n_out_hub;
    logic              r_out_found, n_out_found;
    logic [POS_W-1:0]  r_out_pos,   n_out_pos;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    logic [EDGE_W-1:0] w_hub_c;
    logic [OFF_W-1:0]  w_base_c;
    logic [WALK_W-1:0] w_walk_addr;
    logic              w_walk_in;
    logic              w_idx_off_ok, w_idx_node_ok, w_idx_edge_ok;

    cdof_ram #(.WIDTH(OFF_W), .DEPTH(OFF_DEPTH), .AW(OFF_AW)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (w_off_we),
        .i_waddr (w_off_waddr),
        .i_wdata (w_off_wdata),
        .i_raddr (w_off_raddr),
        .o_rdata (w_off_rd)
    );

    cdof_ram #(.WIDTH(DEG_W), .DEPTH(NODE_COUNT), .AW(DEG_AW)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (w_deg_we),
        .i_waddr (w_deg_waddr),
        .i_wdata (w_deg_wdata),
        .i_raddr (w_deg_raddr),
        .o_rdata (w_deg_rd)
    );

    cdof_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_SLOTS), .AW(EDGE_AW)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (w_edge_waddr),
        .i_wdata (w_edge_wdata),
        .i_raddr (w_edge_raddr),
        .o_rdata (w_edge_rd)
    );

    always_comb begin
        w_idx_off_ok  = 32'(r_idx) < OFF_LIM;
        w_idx_node_ok = 32'(r_idx) < NODE_LIM;
        w_idx_edge_ok = 32'(r_idx) < EDGE_LIM;
        w_walk_addr   = {1'b0, r_base} + WALK_W'(r_i);
        w_walk_in     = 32'(w_walk_addr) < EDGE_LIM;
        w_hub_c       = r_hub_oob ? '0 : w_edge_rd;
        w_base_c      = r_hub_in ? w_off_rd : '0;

        o_stat.fold_ok   = (r_type == REQ_FOLD) && w_idx_node_ok;
        o_stat.walk_done = (r_i >= r_deg) || !w_walk_in;
        o_stat.match     = (IDX_W'(w_edge_rd) == r_idx);
    end

    always_comb begin
        // Store defaults: reads follow the request index, no writes
        w_off_we     = 1'b0;
        w_deg_we     = 1'b0;
        w_edge_we    = 1'b0;
        w_off_raddr  = OFF_AW'(r_idx);
        w_deg_raddr  = DEG_AW'(r_idx);
        w_edge_raddr = EDGE_AW'(r_idx);
        w_off_waddr  = OFF_AW'(r_idx);
        w_deg_waddr  = DEG_AW'(r_idx);
        w_edge_waddr = EDGE_AW'(r_idx);
        w_off_wdata  = r_val;
        w_deg_wdata  = r_val[DEG_W-1:0];
        w_edge_wdata = r_val[EDGE_W-1:0];

        n_type      = r_type;
        n_idx       = r_idx;
        n_val       = r_val;
        n_hub_oob   = r_hub_oob;
        n_hub       = r_hub;
        n_hub_in    = r_hub_in;
        n_base      = r_base;
        n_deg       = r_deg;
        n_i         = r_i;
        n_found     = r_found;
        n_pos       = r_pos;
        n_ebase     = r_ebase;
        n_count     = r_count;
        n_strobe    = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_rval  = r_out_rval;
        n_out_hub   = r_out_hub;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        n_out_count = r_out_count;

        if (i_accept) begin
            n_type = i_req_type;
            n_idx  = i_index;
            n_val  = i_value;
        end

        case (i_ctrl.uop)
            U_HOST_ACC: begin
                case (r_type)
                    REQ_WR_OFF:  w_off_we  = w_idx_off_ok;
                    REQ_WR_EDGE: w_edge_we = w_idx_edge_ok;
                    REQ_WR_DEG:  w_deg_we  = w_idx_node_ok;
                    default:     w_off_we  = 1'b0;
                endcase
            end
            U_HOST_EMIT: begin
                n_strobe    = 1'b1;
                n_out_rval  = '0;
                n_out_hub   = '0;
                n_out_found = 1'b0;
                n_out_pos   = '0;
                n_out_count = r_count;
                case (r_type)
                    REQ_FOLD: n_out_kind = KIND_FOLD;
                    REQ_RD_OFF: begin
                        n_out_kind = KIND_RD_DATA;
                        n_out_rval = w_idx_off_ok ? w_off_rd : '0;
                    end
                    REQ_RD_EDGE: begin
                        n_out_kind = KIND_RD_DATA;
                        n_out_rval = w_idx_edge_ok ? VAL_W'(w_edge_rd) : '0;
                    end
                    REQ_RD_DEG: begin
                        n_out_kind = KIND_RD_DATA;
                        n_out_rval = w_idx_node_ok ? VAL_W'(w_deg_rd) : '0;
                    end
                    default: n_out_kind = KIND_WR_ACK;
                endcase
            end
            U_RD_DOFF: begin
                w_off_raddr = OFF_AW'(r_idx);
            end
            U_RD_HUB: begin
                w_edge_raddr = EDGE_AW'(w_off_rd);
                n_hub_oob    = !(32'(w_off_rd) < EDGE_LIM);
            end
            U_GET_HUB: begin
                n_hub       = w_hub_c;
                n_hub_in    = 32'(w_hub_c) < NODE_LIM;
                w_off_raddr = OFF_AW'(w_hub_c);
                w_deg_raddr = DEG_AW'(w_hub_c);
            end
            U_GET_ROW: begin
                n_base       = w_base_c;
                n_deg        = r_hub_in ? w_deg_rd : '0;
                n_i          = '0;
                n_found      = 1'b0;
                n_pos        = '0;
                w_edge_raddr = EDGE_AW'(w_base_c);
            end
            U_GET_EBASE: begin
                n_ebase = w_edge_rd;
            end
            U_WALK_RD: begin
                w_edge_raddr = EDGE_AW'(w_walk_addr);
            end
            U_WALK_CMP: begin
                if (o_stat.match) begin
                    // Move the first neighbor into the matching slot
                    n_found      = 1'b1;
                    n_pos        = POS_W'(r_i);
                    w_edge_we    = 1'b1;
                    w_edge_waddr = EDGE_AW'(w_walk_addr);
                    w_edge_wdata = r_ebase;
                end else begin
                    n_i = r_i + DEG_W'(1);
                end
            end
            U_SWAP_BASE: begin
                w_edge_we    = 1'b1;
                w_edge_waddr = EDGE_AW'(r_base);
                w_edge_wdata = r_idx[EDGE_W-1:0];
            end
            U_BUMP_D_RD: begin
                w_off_raddr = OFF_AW'(r_idx);
                w_deg_raddr = DEG_AW'(r_idx);
            end
            U_BUMP_D_WR: begin
                w_off_we    = 1'b1;
                w_off_waddr = OFF_AW'(r_idx);
                w_off_wdata = w_off_rd + OFF_W'(1);
                w_deg_we    = 1'b1;
                w_deg_waddr = DEG_AW'(r_idx);
                w_deg_wdata = (w_deg_rd == '0) ? '0 : w_deg_rd - DEG_W'(1);
            end
            U_BUMP_H_RD: begin
                // Reread so a self fold sees the first bump
                w_off_raddr = OFF_AW'(r_hub);
                w_deg_raddr = DEG_AW'(r_hub);
            end
            U_BUMP_H_WR: begin
                w_off_we    = r_hub_in;
                w_off_waddr = OFF_AW'(r_hub);
                w_off_wdata = w_off_rd + OFF_W'(1);
                w_deg_we    = r_hub_in;
                w_deg_waddr = DEG_AW'(r_hub);
                w_deg_wdata = (w_deg_rd == '0) ? '0 : w_deg_rd - DEG_W'(1);
                if (r_count != CNT_MAX) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            U_FOLD_EMIT: begin
                n_strobe    = 1'b1;
                n_out_kind  = KIND_FOLD;
                n_out_rval  = '0;
                n_out_hub   = r_hub;
                n_out_found = r_found;
                n_out_pos   = r_pos;
                n_out_count = r_count;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= n_strobe;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type      <= n_type;
        r_idx       <= n_idx;
        r_val       <= n_val;
        r_hub_oob   <= n_hub_oob;
        r_hub       <= n_hub;
        r_hub_in    <= n_hub_in;
        r_base      <= n_base;
        r_deg       <= n_deg;
        r_i         <= n_i;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_ebase     <= n_ebase;
        r_out_kind  <= n_out_kind;
        r_out_rval  <= n_out_rval;
        r_out_hub   <= n_out_hub;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
        r_out_count <= n_out_count;
    end

    assign o_result_strobe  = r_strobe;
    assign o_result_kind    = r_out_kind;
    assign o_read_value     = r_out_rval;
    assign o_hub_node       = r_out_hub;
    assign o_match_found    = r_out_found;
    assign o_match_position = r_out_pos;
    assign o_fold_count     = r_out_count;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_ctrl.uop == U_HOST_EMIT || i_ctrl.uop == U_FOLD_EMIT))
        else $error("result strobe without an emit step");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("fold counter went backward");

endmodule

// ===== sv/csr_degree_one_folding_unit.sv =====
// Host write/read: accepted at step 0 (idle), then handled in the dispatch and host emit
// steps; the result strobe is registered from the emit step, and no beat is taken while busy.
// Fold: reads the node offset, its hub and the hub row, then walks the row comparing each
// neighbor; a match swaps it to the row head, then both nodes are bumped and the result emitted.
// Results cannot be stalled by the receiver. Reset (sync, active low) clears the step
// counter, strobe and fold counter; the stores come up undefined and are not cleared.
// ============================================================================
// csr_degree_one_folding_unit
// Microcoded CSR graph store that serves host entry access and folds
// degree-one nodes into their hubs.
// ============================================================================
module csr_degree_one_folding_unit #(
    parameter int NODE_COUNT = 1024,
    parameter int EDGE_SLOTS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_req_type,
    input  logic [cdof_pkg::IDX_W-1:0]    i_index,
    input  logic [cdof_pkg::VAL_W-1:0]    i_value,
    output logic                          o_result_strobe,
    output logic [cdof_pkg::KIND_W-1:0]   o_result_kind,
    output logic [cdof_pkg::VAL_W-1:0]    o_read_value,
    output logic [cdof_pkg::EDGE_W-1:0]   o_hub_node,
    output logic                          o_match_found,
    output logic [cdof_pkg::POS_W-1:0]    o_match_position,
    output logic [cdof_pkg::CNT_W-1:0]    o_fold_count
);

    import cdof_pkg::*;

    t_uword w_ctrl;
    t_stat  w_stat;
    logic   w_busy;
    logic   w_accept;

    assign w_accept = start && !w_busy;
    assign busy     = w_busy;

    cdof_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (w_busy)
    );

    cdof_dp #(
        .NODE_COUNT (NODE_COUNT),
        .EDGE_SLOTS (EDGE_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_req_type       (i_req_type),
        .i_index          (i_index),
        .i_value          (i_value),
        .i_ctrl           (w_ctrl),
        .o_stat           (w_stat),
        .o_result_strobe  (o_result_strobe),
        .o_result_kind    (o_result_kind),
        .o_read_value     (o_read_value),
        .o_hub_node       (o_hub_node),
        .o_match_found    (o_match_found),
        .o_match_position (o_match_position),
        .o_fold_count     (o_fold_count)
    );

endmodule

// ===== sim/csr_degree_one_folding_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// csr_degree_one_folding_unit_tb
// Self-checking bench for the CSR degree-one folding unit. Builds small hub
// graphs through host writes, folds their leaves, probes the stores and mixes
// in stray requests. Every result beat is checked in order against a
// bit-true shadow of the graph stores and the fold counter.
// ============================================================================
module csr_degree_one_folding_unit_tb;
    import cdof_pkg::*;

    localparam int NODE_COUNT     = 1024;
    localparam int EDGE_SLOTS     = 4096;
    localparam int HOST_ITEMS     = 1900;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int REPORT_LIMIT   = 10;
    localparam int VAL_MAX        = (1 << VAL_W) - 1;
    localparam int IDX_MAX        = (1 << IDX_W) - 1;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        t_kind             kind;
        logic [VAL_W-1:0]  read_value;
        logic [EDGE_W-1:0] hub;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
    } t_fold_resp;

    class csr_fold_tracker;
        logic [OFF_W-1:0]  offsets [NODE_COUNT+1];
        logic [EDGE_W-1:0] edges   [EDGE_SLOTS];
        logic [DEG_W-1:0]  degrees [NODE_COUNT];
        bit                offset_set [NODE_COUNT+1];
        bit                edge_set   [EDGE_SLOTS];
        bit                degree_set [NODE_COUNT];
        logic [CNT_W-1:0]  folds;
        t_fold_resp        awaited [$];
        int                fault_count;

        function new();
            foreach (offsets[i]) offsets[i] = '0;
            foreach (edges[i]) edges[i] = '0;
            foreach (degrees[i]) degrees[i] = '0;
            folds = '0;
            fault_count = 0;
        endfunction

        function void bump_node(int unsigned node);
            offsets[node] = offsets[node] + 1'b1;
            if (degrees[node] != '0)
                degrees[node] = degrees[node] - 1'b1;
        endfunction

        // True when the fold touches only entries that were written.
        function bit fold_safe(int unsigned d);
            int unsigned hub, deg, base, addr, i;
            if (d >= NODE_COUNT)
                return 1'b1;
            if (!offset_set[d] || !degree_set[d])
                return 1'b0;
            hub = 0;
            if (offsets[d] < EDGE_SLOTS) begin
                if (!edge_set[offsets[d]])
                    return 1'b0;
                hub = edges[offsets[d]];
            end
            if (!offset_set[hub] || !degree_set[hub])
                return 1'b0;
            deg  = degrees[hub];
            base = offsets[hub];
            for (i = 0; i < deg; i++) begin
                addr = base + i;
                if (addr >= EDGE_SLOTS)
                    break;
                if (!edge_set[addr])
                    return 1'b0;
                if (edges[addr] == d)
                    break;
            end
            return 1'b1;
        endfunction

        function bit read_ok(logic [2:0] op, int unsigned idx);
            case (op)
                REQ_RD_OFF:  return idx > NODE_COUNT || offset_set[idx];
                REQ_RD_EDGE: return idx >= EDGE_SLOTS || edge_set[idx];
                REQ_RD_DEG:  return idx >= NODE_COUNT || degree_set[idx];
                default:     return 1'b1;
            endcase
        endfunction

        function t_fold_resp predict_response(logic [2:0] op, logic [IDX_W-1:0] idx,
                                              logic [VAL_W-1:0] val);
            t_fold_resp  r;
            int unsigned hub, deg, base, addr, i;
            logic [EDGE_W-1:0] held;
            r = '0;
            r.kind = KIND_WR_ACK;
            case (op)
                REQ_WR_OFF: begin
                    if (idx <= NODE_COUNT) begin
                        offsets[idx] = val;
                        offset_set[idx] = 1'b1;
                    end
                end
                REQ_WR_EDGE: begin
                    if (idx < EDGE_SLOTS) begin
                        edges[idx] = val[EDGE_W-1:0];
                        edge_set[idx] = 1'b1;
                    end
                end
                REQ_WR_DEG: begin
                    if (idx < NODE_COUNT) begin
                        degrees[idx] = val[DEG_W-1:0];
                        degree_set[idx] = 1'b1;
                    end
                end
                REQ_FOLD: begin
                    r.kind = KIND_FOLD;
                    if (idx < NODE_COUNT) begin
                        hub  = (offsets[idx] < EDGE_SLOTS) ? edges[offsets[idx]] : 0;
                        deg  = degrees[hub];
                        base = offsets[hub];
                        for (i = 0; i < deg; i++) begin
                            addr = base + i;
                            if (addr >= EDGE_SLOTS)
                                break;
                            if (edges[addr] == idx) begin
                                // swap the folded node to the head of the hub's row
                                held = edges[addr];
                                edges[addr] = edges[base];
                                edges[base] = held;
                                r.found = 1'b1;
                                r.position = i[POS_W-1:0];
                                break;
                            end
                        end
                        bump_node(idx);
                        bump_node(hub);
                        if (folds != CNT_MAX)
                            folds = folds + 1'b1;
                        r.hub = hub[EDGE_W-1:0];
                    end
                end
                REQ_RD_OFF: begin
                    r.kind = KIND_RD_DATA;
                    r.read_value = (idx <= NODE_COUNT) ? offsets[idx] : '0;
                end
                REQ_RD_EDGE: begin
                    r.kind = KIND_RD_DATA;
                    r.read_value = (idx < EDGE_SLOTS) ? VAL_W'(edges[idx]) : '0;
                end
                REQ_RD_DEG: begin
                    r.kind = KIND_RD_DATA;
                    r.read_value = (idx < NODE_COUNT) ? VAL_W'(degrees[idx]) : '0;
                end
                default: ;
            endcase
            r.count = folds;
            return r;
        endfunction

        function void note_request(logic [2:0] op, logic [IDX_W-1:0] idx,
                                   logic [VAL_W-1:0] val);
            awaited.push_back(predict_response(op, idx, val));
        endfunction

        function void check_result(t_fold_resp got);
            t_fold_resp want;
            if (awaited.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result beat: kind=%0d value=%0d hub=%0d count=%0d",
                             got.kind, got.read_value, got.hub, got.count);
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.read_value !== want.read_value ||
                got.hub !== want.hub || got.found !== want.found ||
                got.position !== want.position || got.count !== want.count) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display({"result mismatch: expected kind=%0d value=%0d hub=%0d",
                              " found=%0d pos=%0d count=%0d"},
                             want.kind, want.read_value, want.hub, want.found,
                             want.position, want.count);
                    $display({"                 actual   kind=%0d value=%0d hub=%0d",
                              " found=%0d pos=%0d count=%0d"},
                             got.kind, got.read_value, got.hub, got.found,
                             got.position, got.count);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0]       i_req_type = '0;
    logic [IDX_W-1:0] i_index = '0;
    logic [VAL_W-1:0] i_value = '0;

    logic              busy;
    logic              o_result_strobe;
    logic [KIND_W-1:0] o_result_kind;
    logic [VAL_W-1:0]  o_read_value;
    logic [EDGE_W-1:0] o_hub_node;
    logic              o_match_found;
    logic [POS_W-1:0]  o_match_position;
    logic [CNT_W-1:0]  o_fold_count;

    csr_fold_tracker tracker;
    t_fold_resp      seen;
    int unsigned     recent_nodes [$];
    int              sent = 0;
    int              quiet_cycles = 0;
    bit              no_idle = 1'b0;

    csr_degree_one_folding_unit #(
        .NODE_COUNT(NODE_COUNT),
        .EDGE_SLOTS(EDGE_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req_type(i_req_type),
        .i_index(i_index),
        .i_value(i_value),
        .o_result_strobe(o_result_strobe),
        .o_result_kind(o_result_kind),
        .o_read_value(o_read_value),
        .o_hub_node(o_hub_node),
        .o_match_found(o_match_found),
        .o_match_position(o_match_position),
        .o_fold_count(o_fold_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            seen.kind       = t_kind'(o_result_kind);
            seen.read_value = o_read_value;
            seen.hub        = o_hub_node;
            seen.found      = o_match_found;
            seen.position   = o_match_position;
            seen.count      = o_fold_count;
            tracker.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("csr_degree_one_folding_unit test failed");
            $finish;
        end
    end

    task automatic send_req(input logic [2:0] op, input int unsigned idx,
                            input int unsigned val);
        int gap, r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= op;
        i_index    <= idx[IDX_W-1:0];
        i_value    <= val[VAL_W-1:0];
        // hold the beat until the block takes it
        do @(posedge i_clk); while (busy);
        tracker.note_request(op, idx[IDX_W-1:0], val[VAL_W-1:0]);
        if (op != REQ_UNUSED)
            sent++;
    endtask

    function automatic int unsigned pick_node();
        if (recent_nodes.size() == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(0, NODE_COUNT - 1);
        return recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
    endfunction

    function automatic void remember(int unsigned node);
        recent_nodes.push_back(node);
        if (recent_nodes.size() > 24)
            void'(recent_nodes.pop_front());
    endfunction

    // Read an entry; turn the beat into a write when the entry is still unset.
    task automatic probe_entry();
        int unsigned node, idx;
        logic [2:0]  rd_op, wr_op;
        node = pick_node();
        case ($urandom_range(0, 2))
            0: begin
                rd_op = REQ_RD_OFF;
                wr_op = REQ_WR_OFF;
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDX_MAX) : node;
            end
            1: begin
                rd_op = REQ_RD_EDGE;
                wr_op = REQ_WR_EDGE;
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDX_MAX) :
                      (tracker.offsets[node] + $urandom_range(0, 3)) % EDGE_SLOTS;
            end
            default: begin
                rd_op = REQ_RD_DEG;
                wr_op = REQ_WR_DEG;
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDX_MAX) : node;
            end
        endcase
        if (tracker.read_ok(rd_op, idx))
            send_req(rd_op, idx, $urandom_range(0, VAL_MAX));
        else
            send_req(wr_op, idx, $urandom_range(0, VAL_MAX));
    endtask

    task automatic fold_random_node();
        int unsigned node;
        node = ($urandom_range(0, 19) == 0) ? $urandom_range(NODE_COUNT, IDX_MAX) :
               pick_node();
        if (tracker.fold_safe(node))
            send_req(REQ_FOLD, node, $urandom_range(0, VAL_MAX));
        else
            probe_entry();
    endtask

    task automatic scribble();
        logic [2:0] op;
        case ($urandom_range(0, 3))
            0:       op = REQ_WR_OFF;
            1:       op = REQ_WR_EDGE;
            2:       op = REQ_WR_DEG;
            default: op = REQ_UNUSED;
        endcase
        send_req(op, $urandom_range(0, IDX_MAX), $urandom_range(0, VAL_MAX));
    endtask

    // Build a hub with a few degree-one leaves, then fold the leaves.
    task automatic run_episode();
        int unsigned hub, nleaf, deg_h, base, lbase, pick, j, k, held;
        int unsigned leaves [$];
        int unsigned neigh [$];
        bit          dup;
        no_idle = ($urandom_range(0, 5) == 0);
        hub = $urandom_range(0, NODE_COUNT - 1);
        nleaf = $urandom_range(1, 4);
        while (leaves.size() < nleaf) begin
            pick = $urandom_range(0, NODE_COUNT - 1);
            dup = (pick == hub);
            foreach (leaves[m])
                if (leaves[m] == pick)
                    dup = 1'b1;
            if (!dup)
                leaves.push_back(pick);
        end
        foreach (leaves[m])
            neigh.push_back(leaves[m]);
        // sometimes leave a leaf out of the hub row so its fold misses
        if ($urandom_range(0, 7) == 0)
            neigh[0] = $urandom_range(0, NODE_COUNT - 1);
        repeat ($urandom_range(0, 3))
            neigh.push_back($urandom_range(0, NODE_COUNT - 1));
        for (j = neigh.size() - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            held = neigh[j];
            neigh[j] = neigh[k];
            neigh[k] = held;
        end
        deg_h = neigh.size();
        if ($urandom_range(0, 15) == 0)
            base = EDGE_SLOTS - $urandom_range(1, deg_h);
        else
            base = $urandom_range(0, EDGE_SLOTS - 16);
        lbase = (base >= EDGE_SLOTS / 2) ? base - 8 : base + 8;

        send_req(REQ_WR_OFF, hub, base);
        send_req(REQ_WR_DEG, hub, deg_h);
        for (j = 0; j < deg_h; j++)
            if (base + j < EDGE_SLOTS)
                send_req(REQ_WR_EDGE, base + j, neigh[j]);
        for (j = 0; j < nleaf; j++) begin
            send_req(REQ_WR_OFF, leaves[j], lbase + j);
            send_req(REQ_WR_EDGE, lbase + j, hub);
            send_req(REQ_WR_DEG, leaves[j],
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1);
            remember(leaves[j]);
        end
        remember(hub);

        for (j = nleaf - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            held = leaves[j];
            leaves[j] = leaves[k];
            leaves[k] = held;
        end
        foreach (leaves[m]) begin
            if (tracker.fold_safe(leaves[m]))
                send_req(REQ_FOLD, leaves[m], $urandom_range(0, VAL_MAX));
            if ($urandom_range(0, 3) == 0)
                send_req(REQ_RD_DEG, hub, $urandom_range(0, VAL_MAX));
        end
        if ($urandom_range(0, 3) == 0 && tracker.fold_safe(leaves[0]))
            send_req(REQ_FOLD, leaves[0], $urandom_range(0, VAL_MAX));
        if ($urandom_range(0, 5) == 0 && tracker.fold_safe(hub))
            send_req(REQ_FOLD, hub, $urandom_range(0, VAL_MAX));
        if ($urandom_range(0, 1) == 0)
            send_req(REQ_RD_OFF, hub, $urandom_range(0, VAL_MAX));
    endtask

    initial begin
        int sel;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // store edges, masking, stray requests
        send_req(REQ_UNUSED, IDX_MAX, VAL_MAX);
        send_req(REQ_RD_OFF, IDX_MAX, 0);
        send_req(REQ_RD_DEG, NODE_COUNT, 0);
        send_req(REQ_WR_OFF, NODE_COUNT + 1, VAL_MAX);
        send_req(REQ_WR_DEG, 2000, VAL_MAX);
        send_req(REQ_FOLD, IDX_MAX, VAL_MAX);
        send_req(REQ_WR_OFF, NODE_COUNT, VAL_MAX);
        send_req(REQ_RD_OFF, NODE_COUNT, 0);
        send_req(REQ_WR_EDGE, EDGE_SLOTS - 1, VAL_MAX);
        send_req(REQ_RD_EDGE, EDGE_SLOTS - 1, 0);
        send_req(REQ_WR_DEG, NODE_COUNT - 1, VAL_MAX);
        send_req(REQ_RD_DEG, NODE_COUNT - 1, 0);
        // node linked to itself
        send_req(REQ_WR_OFF, 5, 100);
        send_req(REQ_WR_EDGE, 100, 5);
        send_req(REQ_WR_DEG, 5, 1);
        send_req(REQ_FOLD, 5, 0);
        // offset past the edge store gives hub zero; offset wraps; walk runs off the end
        send_req(REQ_WR_OFF, 1, VAL_MAX);
        send_req(REQ_WR_DEG, 1, 0);
        send_req(REQ_WR_OFF, 0, EDGE_SLOTS - 2);
        send_req(REQ_WR_DEG, 0, 3);
        send_req(REQ_WR_EDGE, EDGE_SLOTS - 2, 7);
        send_req(REQ_FOLD, 1, 0);
        send_req(REQ_RD_OFF, 1, 0);
        send_req(REQ_RD_DEG, 0, 0);

        while (sent < HOST_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                run_episode();
            else if (sel < 70)
                fold_random_node();
            else if (sel < 88)
                probe_entry();
            else
                scribble();
        end
        start <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.fault_count == 0 && tracker.awaited.size() == 0)
            $display("csr_degree_one_folding_unit test passed");
        else
            $display("csr_degree_one_folding_unit test failed");
        $finish;
    end

endmodule

// ===== csr_degree_one_folding_unit.f =====
sv/cdof_pkg.sv
sv/cdof_ram.sv
sv/cdof_seq.sv
sv/cdof_dp.sv
sv/csr_degree_one_folding_unit.sv
sim/csr_degree_one_folding_unit_tb.sv
